// ===== rtl/hde_pkg.sv =====
// Shared types, constants and entity tables for the HTML entity stream decoder.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package hde_pkg;

	localparam int ENT_COUNT   = 5;
	localparam int ENT_MAX_LEN = 6;
	localparam int PEND_DEPTH  = ENT_MAX_LEN - 1;
	localparam int RUN_MAX     = PEND_DEPTH + 1;
	localparam int CMDQ_DEPTH  = 4;
	localparam int CNT_W       = $clog2(RUN_MAX + 1);
	localparam int PIDX_W      = $clog2(PEND_DEPTH);

	localparam logic [7:0] AMP_CHAR = 8'h26;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [PIDX_W-1:0] pidx_t;
	typedef logic [2:0]        ent_idx_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_word_t;

	// One decoded run: run[0] goes out first, len bytes in total.
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] run;
		cnt_t                    len;
	} cmd_t;

	// Entity text, first character in the top byte, padded with zeros.
	function automatic logic [ENT_MAX_LEN*8-1:0] ent_text(input ent_idx_t e);
		case (e)
			3'd0:    ent_text = "&quot;";
			3'd1:    ent_text = "&apos;";
			3'd2:    ent_text = {"&lt;", 16'h0000};
			3'd3:    ent_text = {"&gt;", 16'h0000};
			3'd4:    ent_text = {"&amp;", 8'h00};
			default: ent_text = '0;
		endcase
	endfunction

	function automatic cnt_t ent_len(input ent_idx_t e);
		case (e)
			3'd0:    ent_len = cnt_t'(6);
			3'd1:    ent_len = cnt_t'(6);
			3'd2:    ent_len = cnt_t'(4);
			3'd3:    ent_len = cnt_t'(4);
			3'd4:    ent_len = cnt_t'(5);
			default: ent_len = '0;
		endcase
	endfunction

	function automatic logic [7:0] ent_sym(input ent_idx_t e);
		case (e)
			3'd0:    ent_sym = 8'h22;
			3'd1:    ent_sym = 8'h27;
			3'd2:    ent_sym = 8'h3C;
			3'd3:    ent_sym = 8'h3E;
			3'd4:    ent_sym = 8'h26;
			default: ent_sym = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] ent_char(input ent_idx_t e, input cnt_t k);
		logic [ENT_MAX_LEN*8-1:0] t;
		t = ent_text(e);
		if (int'(k) < ENT_MAX_LEN) begin
			ent_char = t[8*(ENT_MAX_LEN-1-int'(k)) +: 8];
		end else begin
			ent_char = 8'h00;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hde_front.sv =====
// Front end: holds the pending entity prefix, matches each byte and builds a run.
// Depends on hde_pkg.
`default_nettype none

module hde_front
	import hde_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       take,
	input  in_word_t  in_word,
	output logic      cmd_push,
	output cmd_t      cmd
);

	logic [PEND_DEPTH-1:0][7:0] pend_q;
	cnt_t                       pend_cnt_q;

	logic [ENT_COUNT-1:0] hit;
	logic                 full_hit;
	logic                 prefix_hit;
	logic                 hold_amp;
	logic [7:0]           sym;
	logic [7:0]           b;
	logic                 eot;
	cnt_t                 nxt_cnt;
	logic                 wr_en;
	pidx_t                wr_idx;

	assign b   = in_word.in_byte;
	assign eot = in_word.end_of_text;

	// Match the held prefix plus the new byte against every entity.
	always_comb begin
		hit        = '0;
		full_hit   = 1'b0;
		prefix_hit = 1'b0;
		sym        = 8'h00;
		for (int e = 0; e < ENT_COUNT; e++) begin
			hit[e] = (pend_cnt_q != '0) && (pend_cnt_q < ent_len(ent_idx_t'(e)))
				&& (ent_char(ent_idx_t'(e), pend_cnt_q) == b);
			for (int k = 0; k < PEND_DEPTH; k++) begin
				if ((cnt_t'(k) < pend_cnt_q) && (ent_char(ent_idx_t'(e), cnt_t'(k)) != pend_q[k])) begin
					hit[e] = 1'b0;
				end
			end
			if (hit[e]) begin
				if (pend_cnt_q + cnt_t'(1) == ent_len(ent_idx_t'(e))) begin
					full_hit = 1'b1;
					sym      = ent_sym(ent_idx_t'(e));
				end else begin
					prefix_hit = 1'b1;
				end
			end
		end
	end

	// Build the run: held bytes in order, then the new byte, or the entity's symbol on a full match.
	always_comb begin
		for (int i = 0; i < PEND_DEPTH; i++) begin
			cmd.run[i] = (cnt_t'(i) < pend_cnt_q) ? pend_q[i] : b;
		end
		cmd.run[RUN_MAX-1] = b;
		hold_amp = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = pidx_t'(pend_cnt_q);
		if (full_hit) begin
			cmd.run[0] = sym;
			cmd.len    = cnt_t'(1);
			nxt_cnt    = '0;
		end else if (prefix_hit) begin
			if (eot) begin
				cmd.len = pend_cnt_q + cnt_t'(1);
				nxt_cnt = '0;
			end else begin
				cmd.len = '0;
				wr_en   = 1'b1;
				nxt_cnt = pend_cnt_q + cnt_t'(1);
			end
		end else begin
			hold_amp = (b == AMP_CHAR) && !eot;
			cmd.len  = pend_cnt_q + cnt_t'(!hold_amp);
			nxt_cnt  = hold_amp ? cnt_t'(1) : '0;
			wr_en    = hold_amp;
			wr_idx   = '0;
		end
	end

	assign cmd_push = take && (cmd.len != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
		end else if (take) begin
			pend_cnt_q <= nxt_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			pend_q[wr_idx] <= b;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hde_cmd_fifo.sv =====
// Short run queue between the front end and the serializer.
// Depends on hde_pkg.
`default_nettype none

module hde_cmd_fifo
	import hde_pkg::*;
#(
	parameter int DEPTH = CMDQ_DEPTH
)
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   wr,
	input  cmd_t  wr_data,
	output logic  full,
	input  wire   rd,
	output cmd_t  rd_data,
	output logic  empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int QCNT_W = $clog2(DEPTH + 1);

	cmd_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (cnt_q == QCNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hde_back.sv =====
// Back end: takes one run from the queue and hands it out a word per pop.
// Depends on hde_pkg.
`default_nettype none

module hde_back
	import hde_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        q_empty,
	input  cmd_t       q_data,
	output logic       q_pop,
	output logic       empty,
	input  wire        pop,
	output out_word_t  out_word
);

	logic [RUN_MAX-1:0][7:0] run_q;
	cnt_t                    left_q;
	logic                    busy;
	logic                    done;

	assign busy  = (left_q != '0);
	assign empty = !busy;
	assign done  = !busy || (pop && left_q == cnt_t'(1));
	assign q_pop = done && !q_empty;

	assign out_word.out_byte    = run_q[0];
	assign out_word.last_of_run = (left_q == cnt_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (q_pop) begin
			left_q <= q_data.len;
		end else if (done) begin
			left_q <= '0;
		end else if (pop) begin
			left_q <= left_q - cnt_t'(1);
		end
	end

	// Advance the run one byte per pop, reload when it is used up.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			run_q <= q_data.run;
		end else if (pop && busy) begin
			run_q <= run_q >> 8;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/html_entity_stream_decoder_top.sv =====
// Top level of the HTML entity stream decoder.
// Depends on hde_pkg, hde_front, hde_cmd_fifo and hde_back.
//
// Input: drive in_word (one text byte plus end_of_text) and raise push; a word
//   is taken at a rising edge with push high and full low.
// Output: while empty is low, out_word holds the oldest decoded byte; raise pop
//   to take it. last_of_run marks the final byte produced by one input word.
// The named entities quot, apos, lt, gt and amp collapse to one character.
//   Bytes that may still form an entity are held; a broken match releases them
//   unchanged, and end_of_text flushes them.
// A word that produces output is written to the run queue at the edge
//   that takes it and loaded into the serializer once the run before it has
//   been handed out; from then it is on out_word.
// Throughput: one input word per cycle while the run queue has room; output one
//   byte per cycle while pop is high, up to six bytes for one input word.
//   Held-only words queue no run. QUEUE_DEPTH (four by default) runs absorb bursts.
// Reset: arst_n clears the held count, the queue and the serializer; empty goes
//   high and full low. Stall: with pop low the current byte holds, the queue
//   fills and full rises; no word is lost or duplicated.
`default_nettype none

module html_entity_stream_decoder_top
	import hde_pkg::*;
#(
	parameter int QUEUE_DEPTH = CMDQ_DEPTH
)
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  in_word_t   in_word,
	output logic       empty,
	input  wire        pop,
	output out_word_t  out_word
);

	logic take;
	logic cmd_push;
	cmd_t cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	cmd_t q_data;

	// Accept input only while the run queue can take one more run.
	assign full = q_full;
	assign take = push && !q_full;

	hde_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.in_word  (in_word),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	hde_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.wr_data (cmd),
		.full    (q_full),
		.rd      (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	hde_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_word (out_word)
	);

endmodule

`default_nettype wire

// ===== rtl/hde_checker.sv =====
// Port-level checks for html_entity_stream_decoder_top, attached by bind.
// Depends on hde_pkg.
`default_nettype none

module hde_checker
	import hde_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        push,
	input wire        full,
	input wire        empty,
	input wire        pop,
	input out_word_t  out_word
);

	// Hold the offered word until it is popped.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_word)))
		else $error("out_word changed while waiting for pop");

	// Leave reset with nothing to offer and room to accept.
	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (empty && !full))
		else $error("bad state right after reset");

	// Stay empty when nothing was accepted recently.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !(push && !full) && !$past(push && !full)) |=> empty)
		else $error("output appeared without an accepted word");

	// A full queue implies the serializer is busy.
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full while serializer idle");

endmodule

bind html_entity_stream_decoder_top hde_checker u_hde_checker (.*);

`default_nettype wire
